FILE: design/isim_pkg.sv
// ----------------------------------------------------------------------------
// isim_pkg: shared types for the interval set insert/merge block
// Command codes, status codes, sequencer states and the merge decision.
// ----------------------------------------------------------------------------
package isim_pkg;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_DUMP   = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_PROC,
    S_TAIL,
    S_RESP,
    S_DUMP_RD,
    S_DUMP_EMIT
  } state_e;

  typedef struct packed {
    logic        place;   // pending goes before the entry
    logic        keep;    // entry is copied unchanged
    logic [31:0] hull_s;
    logic [31:0] hull_e;
  } merge_t;

endpackage

FILE: design/isim_mem.sv
// ----------------------------------------------------------------------------
// isim_mem: two-bank interval table
// One write and one registered read per cycle; each word is {end, start}.
// ----------------------------------------------------------------------------
module isim_mem #(
  parameter int AW = 6
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [63:0]   wr_data_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [63:0]   rd_data_o
);

  logic [63:0] mem [2**AW];
  logic [63:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: design/isim_merge.sv
// ----------------------------------------------------------------------------
// isim_merge: compare and hull unit
// Decides whether the pending interval goes before, passes, or absorbs an entry.
// ----------------------------------------------------------------------------
module isim_merge
  import isim_pkg::*;
(
  input  logic        placed_i,
  input  logic [31:0] ps_i,
  input  logic [31:0] pe_i,
  input  logic [31:0] es_i,
  input  logic [31:0] ee_i,
  output merge_t      res_o
);

  logic lies_below;
  logic after;

  // 33-bit compares so end+1 never wraps
  assign lies_below = ({1'b0, pe_i} + 33'd1) < {1'b0, es_i};
  assign after      = {1'b0, ps_i} > ({1'b0, ee_i} + 33'd1);

  always_comb begin
    res_o.place  = !placed_i && lies_below;
    res_o.keep   = placed_i || after;
    res_o.hull_s = (es_i < ps_i) ? es_i : ps_i;
    res_o.hull_e = (ee_i > pe_i) ? ee_i : pe_i;
  end

endmodule

FILE: design/interval_set_insert_merge.sv
// ----------------------------------------------------------------------------
// interval_set_insert_merge: sorted interval table with insert and merge
// ----------------------------------------------------------------------------
// Input beats carry a command in s_axis_tuser and an interval in s_axis_tdata.
// Append, insert and clear return one status beat; dump returns one beat per
// stored interval (or one empty-status beat), with m_axis_tlast on the final.
// Append and clear go straight to the response state. Insert sweeps the
// table through one shared compare/hull unit: each stored entry takes a
// memory read, then a decision and write, and one more decision step copies
// the entry where the new interval is placed; a tail step follows the sweep.
// The sweep writes the new table into the spare memory bank and flips banks
// only when it fit, so a full table stays untouched. Dump reads, then emits
// each entry. One item is in work at a time; s_axis_tready is high only while idle.
// Reset empties the table and clears the output valid flag; memory contents are
// not cleared. A stalled receiver holds the output beat and the sequencer.
// ----------------------------------------------------------------------------
module interval_set_insert_merge
  import isim_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // seg_start[31:0], seg_end[63:32]
  input  logic [1:0]  s_axis_tuser_i,   // cmd[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // status, out_start, out_end, table_count
  output logic        m_axis_tlast_o
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int AW = IW + 1;
  localparam logic [CW-1:0] DEPTH = CW'(TABLE_DEPTH);

  state_e state_q, state_d;
  logic [1:0]    cmd_q, cmd_d;
  logic [31:0]   ps_q, ps_d, pe_q, pe_d;
  logic [CW-1:0] j_q, j_d, w_q, w_d, cnt_q, cnt_d;
  logic          placed_q, placed_d, ovf_q, ovf_d, bank_q, bank_d;
  logic [1:0]    status_q, status_d;

  logic          out_valid_q;
  logic [71:0]   out_data_q;
  logic          out_last_q;
  logic          out_free;
  logic          out_load;
  logic [71:0]   out_data_d;
  logic          out_last_d;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [63:0]   wr_data, rd_data;
  merge_t        mres;
  logic          accept;
  logic [CW-1:0] j_inc;
  logic          tail_ovf;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign accept   = s_axis_tvalid_i && (state_q == S_IDLE);
  assign j_inc    = j_q + CW'(1);
  assign tail_ovf = ovf_q || (!placed_q && (w_q == DEPTH));

  isim_mem #(.AW(AW)) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  isim_merge u_merge (
    .placed_i (placed_q),
    .ps_i     (ps_q),
    .pe_i     (pe_q),
    .es_i     (rd_data[31:0]),
    .ee_i     (rd_data[63:32]),
    .res_o    (mres)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (s_axis_tuser_i)
            CMD_INSERT: state_d = (cnt_q == '0) ? S_TAIL : S_RD;
            CMD_DUMP:   state_d = (cnt_q == '0) ? S_RESP : S_DUMP_RD;
            default:    state_d = S_RESP;
          endcase
        end
      end
      S_RD: state_d = S_PROC;
      S_PROC: begin
        if (!mres.place) begin
          state_d = (j_inc == cnt_q) ? S_TAIL : S_RD;
        end
      end
      S_TAIL: state_d = S_RESP;
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      S_DUMP_RD: state_d = S_DUMP_EMIT;
      S_DUMP_EMIT: begin
        if (out_free) state_d = (j_inc == cnt_q) ? S_IDLE : S_DUMP_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cmd_d = cmd_q; ps_d = ps_q; pe_d = pe_q;
    j_d = j_q; w_d = w_q; cnt_d = cnt_q;
    placed_d = placed_q; ovf_d = ovf_q; bank_d = bank_q; status_d = status_q;
    wr_en = 1'b0; wr_addr = {~bank_q, w_q[IW-1:0]}; wr_data = {pe_q, ps_q};
    rd_en = 1'b0; rd_addr = {bank_q, j_q[IW-1:0]};
    out_load = 1'b0; out_data_d = out_data_q; out_last_d = out_last_q;
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (accept) begin
          cmd_d    = s_axis_tuser_i;
          ps_d     = s_axis_tdata_i[31:0];
          pe_d     = s_axis_tdata_i[63:32];
          j_d      = '0;
          w_d      = '0;
          placed_d = 1'b0;
          ovf_d    = 1'b0;
          status_d = ST_OK;
          unique case (s_axis_tuser_i)
            CMD_APPEND: begin
              if (cnt_q < DEPTH) begin
                wr_en   = 1'b1;
                wr_addr = {bank_q, cnt_q[IW-1:0]};
                wr_data = s_axis_tdata_i;
                cnt_d   = cnt_q + CW'(1);
              end else begin
                status_d = ST_FULL;
              end
            end
            CMD_DUMP: begin
              if (cnt_q == '0) status_d = ST_EMPTY;
            end
            CMD_CLEAR: cnt_d = '0;
            default: ;
          endcase
        end
      end
      S_RD, S_DUMP_RD: rd_en = 1'b1;
      S_PROC: begin
        if (mres.place || mres.keep) begin
          wr_data = mres.place ? {pe_q, ps_q} : rd_data;
          if (w_q == DEPTH) begin
            ovf_d = 1'b1;
          end else begin
            wr_en = 1'b1;
            w_d   = w_q + CW'(1);
          end
        end else begin
          ps_d = mres.hull_s;
          pe_d = mres.hull_e;
        end
        if (mres.place) begin
          placed_d = 1'b1;   // hold j, the same entry is copied next cycle
        end else begin
          j_d = j_inc;
        end
      end
      S_TAIL: begin
        if (!placed_q && (w_q != DEPTH)) begin
          wr_en = 1'b1;
        end
        if (tail_ovf) begin
          status_d = ST_FULL;
        end else begin
          bank_d = ~bank_q;
          cnt_d  = placed_q ? w_q : w_q + CW'(1);
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_data_d = {6'(cnt_q), 64'd0, status_q};
          out_last_d = 1'b1;
        end
      end
      S_DUMP_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_data_d = {6'(cnt_q), rd_data, ST_OK};
          out_last_d = (j_inc == cnt_q);
          j_d        = j_inc;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      bank_q      <= 1'b0;
      placed_q    <= 1'b0;
      ovf_q       <= 1'b0;
      j_q         <= '0;
      w_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      bank_q   <= bank_d;
      placed_q <= placed_d;
      ovf_q    <= ovf_d;
      j_q      <= j_d;
      w_q      <= w_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    ps_q     <= ps_d;
    pe_q     <= pe_d;
    status_q <= status_d;
    if (out_load) begin
      out_data_q <= out_data_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DEPTH) else $error("table count above depth");

  a_w_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    w_q <= DEPTH) else $error("write index above depth");

  a_sweep_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROC || state_q == S_DUMP_EMIT) |-> j_q < cnt_q)
    else $error("sweep index past table end");

  a_full_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TAIL && tail_ovf) |=> (cnt_q == $past(cnt_q) &&
      bank_q == $past(bank_q))) else $error("full insert changed the table");

  a_insert_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROC || state_q == S_TAIL) |-> cmd_q == CMD_INSERT)
    else $error("sweep running for a non-insert command");

endmodule
